// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/itf_pkg.sv =====
package itf_pkg;

    // Default configuration
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_FIELD_DEF  = 48;

    // Bits consumed by one divider step
    localparam int DIV_CHUNK = 8;

    // Characters
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_X     = 8'h58;
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] LC_BIT    = 8'h20;

    // Input item
    typedef struct packed {
        logic [31:0] value;
        logic        signed_mode;
        logic [4:0]  radix;
        logic [5:0]  min_width;
        logic [5:0]  min_digits;
        logic        zero_pad;
        logic        left_justify;
        logic        show_plus;
        logic        space_sign;
        logic        alt_prefix;
        logic        lower_case;
    } itf_in_t;

    // Result item
    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       bad_base;
    } itf_out_t;

    // Controller states, in emission order from SETUP on
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SETUP,
        ST_PLAN,
        ST_LEAD,
        ST_SIGN,
        ST_PFX0,
        ST_PFXX,
        ST_FILL,
        ST_PZERO,
        ST_DIGIT,
        ST_TRAIL,
        ST_BAD
    } state_t;

    // Character source for one emitted item
    typedef enum logic [2:0] {
        CH_PAD_SPACE,
        CH_SIGN,
        CH_PFX_ZERO,
        CH_PFX_X,
        CH_FILL_ZERO,
        CH_PREC_ZERO,
        CH_DIGIT,
        CH_BAD
    } chsel_t;

    // Where the width padding goes
    typedef enum logic [1:0] {
        PAD_LEAD,
        PAD_FILL,
        PAD_TRAIL
    } pad_mode_t;

    // Controller to datapath
    typedef struct packed {
        logic   load;
        logic   div_step;
        logic   setup;
        logic   emit;
        chsel_t sel;
        logic   last;
    } itf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic      bad;
        logic      div_done;
        logic      out_free;
        logic      has_sign;
        logic [1:0] pfx_len;
        pad_mode_t pad_mode;
        logic      pad_nz;
        logic      pad_one;
        logic      zero_nz;
        logic      zero_one;
        logic      dig_final;
    } itf_status_t;

    // Upper-case digit character for 0..15
    function automatic logic [7:0] digit_char(logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHR_ZERO + {4'b0000, d};
        end else begin
            c = 8'h37 + {4'b0000, d};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/itf_dpath.sv =====
module itf_dpath
    import itf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  itf_in_t     s_item,
    output itf_out_t    m_item,
    output logic        m_valid,
    input  logic        m_ready,
    input  itf_cmd_t    cmd,
    output itf_status_t status
);

    localparam int NCH   = (VALUE_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
    localparam int DIV_W = NCH * DIV_CHUNK;
    localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int ND_W  = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam logic [5:0] MAX_F = 6'(MAX_FIELD);

    // Item and working registers
    itf_in_t                req_reg;
    logic [DIV_W-1:0]       quo_reg,  quo_next;
    logic [3:0]             rem_reg,  rem_next;
    logic [CNT_W-1:0]       chunk_reg, chunk_next;
    logic [ND_W-1:0]        nd_reg,   nd_next;
    logic [3:0]             dig_reg [VALUE_BITS];
    logic [5:0]             pad_reg;
    logic [5:0]             zero_reg;
    logic [ND_W-1:0]        k_reg;
    logic                   comma_done_reg;
    logic [7:0]             sign_char_reg;
    logic                   has_sign_reg;
    pad_mode_t              pad_mode_reg;
    itf_out_t               out_reg;
    logic                   m_valid_reg;

    // Capture decode
    logic [VALUE_BITS-1:0]  in_v;
    logic                   in_neg;
    logic [VALUE_BITS-1:0]  in_mag;

    // Radix decode
    logic                   pow2;
    logic [2:0]             pow_sh;
    logic [3:0]             pow_mask;
    logic [1:0]             pfx_len;

    // Divider step
    logic [DIV_CHUNK-1:0]   div_top;
    logic [DIV_CHUNK-1:0]   div_q;
    logic [3:0]             div_rem;
    logic [4:0]             div_trial;
    logic                   chunk_last;
    logic                   dig_we;
    logic [3:0]             dig_wdata;

    // Setup arithmetic
    logic [5:0]             width_sat;
    logic [5:0]             prec_sat;
    logic [5:0]             nd_ext;
    logic [5:0]             prec_eff;
    logic signed [7:0]      setup_w;

    // Emission
    logic                   need_comma;
    logic [ND_W-1:0]        k_dec;
    logic [7:0]             lc;
    logic [7:0]             emit_char;

    // Capture: magnitude and sign of the incoming value
    assign in_v   = s_item.value[VALUE_BITS-1:0];
    assign in_neg = s_item.signed_mode & in_v[VALUE_BITS-1];
    assign in_mag = in_neg ? (-in_v) : in_v;

    // Decode power-of-two bases and prefix length
    always_comb begin
        pow2     = 1'b1;
        pow_sh   = 3'd1;
        unique case (req_reg.radix)
            5'd2:    pow_sh = 3'd1;
            5'd4:    pow_sh = 3'd2;
            5'd8:    pow_sh = 3'd3;
            5'd16:   pow_sh = 3'd4;
            default: pow2   = 1'b0;
        endcase
        pow_mask = 4'(req_reg.radix - 5'd1);
        pfx_len  = 2'd0;
        if (req_reg.alt_prefix && req_reg.radix == 5'd16) begin
            pfx_len = 2'd2;
        end else if (req_reg.alt_prefix && req_reg.radix == 5'd8) begin
            pfx_len = 2'd1;
        end
    end

    // Restoring division of one chunk by the radix, MSB first
    assign div_top = quo_reg[DIV_W-1 -: DIV_CHUNK];
    always_comb begin
        div_rem   = rem_reg;
        div_q     = '0;
        div_trial = '0;
        for (int i = DIV_CHUNK - 1; i >= 0; i--) begin
            div_trial = {div_rem, div_top[i]};
            if (div_trial >= req_reg.radix) begin
                div_q[i] = 1'b1;
                div_rem  = 4'(div_trial - req_reg.radix);
            end else begin
                div_rem  = div_trial[3:0];
            end
        end
    end

    assign chunk_last = (chunk_reg == CNT_W'(NCH - 1));

    // Next values of the digit generator
    always_comb begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        nd_next    = nd_reg;
        dig_we     = 1'b0;
        dig_wdata  = '0;
        if (cmd.load) begin
            quo_next   = DIV_W'(in_mag);
            rem_next   = '0;
            chunk_next = '0;
            nd_next    = '0;
        end else if (cmd.div_step) begin
            if (pow2) begin
                dig_we    = 1'b1;
                dig_wdata = quo_reg[3:0] & pow_mask;
                quo_next  = quo_reg >> pow_sh;
                nd_next   = nd_reg + 1'b1;
            end else begin
                quo_next = DIV_W'({quo_reg, div_q});
                if (chunk_last) begin
                    dig_we     = 1'b1;
                    dig_wdata  = div_rem;
                    rem_next   = '0;
                    chunk_next = '0;
                    nd_next    = nd_reg + 1'b1;
                end else begin
                    rem_next   = div_rem;
                    chunk_next = chunk_reg + 1'b1;
                end
            end
        end
    end

    // Setup: saturate width and precision, size the padding
    always_comb begin
        width_sat = (req_reg.min_width > MAX_F) ? MAX_F : req_reg.min_width;
        prec_sat  = (req_reg.min_digits > MAX_F) ? MAX_F : req_reg.min_digits;
        nd_ext    = 6'(nd_reg);
        prec_eff  = (nd_ext > prec_sat) ? nd_ext : prec_sat;
        setup_w   = $signed({2'b00, width_sat})
                  - $signed({7'b0000000, has_sign_reg})
                  - $signed({6'b000000, pfx_len})
                  - $signed({2'b00, prec_eff});
    end

    // Character selection for the current item
    assign k_dec      = k_reg - 1'b1;
    assign lc         = req_reg.lower_case ? LC_BIT : 8'h00;
    assign need_comma = (req_reg.radix == 5'd2) && (k_reg != nd_reg)
                        && (k_reg[2:0] == 3'd0) && !comma_done_reg;

    always_comb begin
        unique case (cmd.sel)
            CH_PAD_SPACE: emit_char = CHR_SPACE;
            CH_SIGN:      emit_char = sign_char_reg;
            CH_PFX_ZERO:  emit_char = CHR_ZERO;
            CH_PFX_X:     emit_char = CHR_X | lc;
            CH_FILL_ZERO: emit_char = CHR_ZERO;
            CH_PREC_ZERO: emit_char = CHR_ZERO;
            CH_DIGIT:     emit_char = need_comma ? CHR_COMMA
                                      : (digit_char(dig_reg[k_dec[IDX_W-1:0]]) | lc);
            CH_BAD:       emit_char = CHR_NUL;
            default:      emit_char = CHR_NUL;
        endcase
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg <= '0;
            nd_reg    <= '0;
        end else begin
            chunk_reg <= chunk_next;
            nd_reg    <= nd_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (dig_we) begin
            dig_reg[nd_reg[IDX_W-1:0]] <= dig_wdata;
        end
        // Capture item and sign decisions
        if (cmd.load) begin
            req_reg      <= s_item;
            has_sign_reg <= s_item.signed_mode
                            & (in_neg | s_item.show_plus | s_item.space_sign);
            if (in_neg) begin
                sign_char_reg <= CHR_MINUS;
            end else if (s_item.show_plus) begin
                sign_char_reg <= CHR_PLUS;
            end else begin
                sign_char_reg <= CHR_SPACE;
            end
        end
        // Load counters once the digit count is known
        if (cmd.setup) begin
            pad_reg        <= (setup_w > 8'sd0) ? setup_w[5:0] : 6'd0;
            zero_reg       <= prec_eff - nd_ext;
            k_reg          <= nd_reg;
            comma_done_reg <= 1'b0;
            if (req_reg.left_justify) begin
                pad_mode_reg <= PAD_TRAIL;
            end else if (req_reg.zero_pad) begin
                pad_mode_reg <= PAD_FILL;
            end else begin
                pad_mode_reg <= PAD_LEAD;
            end
        end
        // Advance counters on each emitted character
        if (cmd.emit) begin
            unique case (cmd.sel)
                CH_PAD_SPACE, CH_FILL_ZERO: pad_reg <= pad_reg - 6'd1;
                CH_PREC_ZERO: zero_reg <= zero_reg - 6'd1;
                CH_DIGIT: begin
                    if (need_comma) begin
                        comma_done_reg <= 1'b1;
                    end else begin
                        k_reg          <= k_dec;
                        comma_done_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            out_reg.character <= emit_char;
            out_reg.last      <= cmd.last;
            out_reg.bad_base  <= (cmd.sel == CH_BAD);
        end
    end

    assign m_item  = out_reg;
    assign m_valid = m_valid_reg;

    // Status toward the controller
    always_comb begin
        status.bad       = (req_reg.radix < 5'd2) || (req_reg.radix > 5'd16);
        status.div_done  = (nd_reg != '0) && (quo_reg == '0) && (chunk_reg == '0);
        status.out_free  = !m_valid_reg || m_ready;
        status.has_sign  = has_sign_reg;
        status.pfx_len   = pfx_len;
        status.pad_mode  = pad_mode_reg;
        status.pad_nz    = (pad_reg != 6'd0);
        status.pad_one   = (pad_reg == 6'd1);
        status.zero_nz   = (zero_reg != 6'd0);
        status.zero_one  = (zero_reg == 6'd1);
        status.dig_final = (k_reg == ND_W'(1));
    end

endmodule

// ===== rtl/core/itf_ctrl.sv =====
module itf_ctrl
    import itf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  itf_status_t status,
    output itf_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   trail_on;

    assign trail_on = status.pad_nz && (status.pad_mode == PAD_TRAIL);

    // First non-empty phase after the given one, up to the digits
    function automatic state_t phase_after(state_t from, itf_status_t st);
        state_t nx;
        nx = ST_DIGIT;
        if (st.zero_nz && from < ST_PZERO) begin
            nx = ST_PZERO;
        end
        if (st.pad_nz && st.pad_mode == PAD_FILL && from < ST_FILL) begin
            nx = ST_FILL;
        end
        if (st.pfx_len == 2'd2 && from < ST_PFXX) begin
            nx = ST_PFXX;
        end
        if (st.pfx_len != 2'd0 && from < ST_PFX0) begin
            nx = ST_PFX0;
        end
        if (st.has_sign && from < ST_SIGN) begin
            nx = ST_SIGN;
        end
        if (st.pad_nz && st.pad_mode == PAD_LEAD && from < ST_LEAD) begin
            nx = ST_LEAD;
        end
        return nx;
    endfunction

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (status.bad) begin
                    state_next = ST_BAD;
                end else if (status.div_done) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_PLAN;
            ST_PLAN:  state_next = phase_after(ST_PLAN, status);
            ST_LEAD: begin
                if (status.out_free && status.pad_one) begin
                    state_next = phase_after(ST_LEAD, status);
                end
            end
            ST_SIGN, ST_PFX0, ST_PFXX: begin
                if (status.out_free) state_next = phase_after(state_reg, status);
            end
            ST_FILL: begin
                if (status.out_free && status.pad_one) begin
                    state_next = phase_after(ST_FILL, status);
                end
            end
            ST_PZERO: begin
                if (status.out_free && status.zero_one) begin
                    state_next = phase_after(ST_PZERO, status);
                end
            end
            ST_DIGIT: begin
                if (status.out_free && status.dig_final) begin
                    state_next = trail_on ? ST_TRAIL : ST_IDLE;
                end
            end
            ST_TRAIL: begin
                if (status.out_free && status.pad_one) state_next = ST_IDLE;
            end
            ST_BAD: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        cmd.sel  = CH_PAD_SPACE;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIVIDE: cmd.div_step = !status.bad && !status.div_done;
            ST_SETUP:  cmd.setup = 1'b1;
            ST_PLAN:   ;
            ST_LEAD: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_PAD_SPACE;
            end
            ST_SIGN: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_SIGN;
            end
            ST_PFX0: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_PFX_ZERO;
            end
            ST_PFXX: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_PFX_X;
            end
            ST_FILL: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_FILL_ZERO;
            end
            ST_PZERO: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_PREC_ZERO;
            end
            ST_DIGIT: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_DIGIT;
                cmd.last = status.dig_final && !trail_on;
            end
            ST_TRAIL: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_PAD_SPACE;
                cmd.last = status.pad_one;
            end
            ST_BAD: begin
                cmd.emit = status.out_free;
                cmd.sel  = CH_BAD;
                cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/integer_to_text_formatter.sv =====
// Formats one integer as text, one character per result item, printf style:
// leading spaces, sign, "0"/"0X" prefix, zero fill, precision zeros, digits
// (base 2 with a comma between groups of eight), trailing spaces. A base
// outside 2..16 yields one item with bad_base set. Items are processed one at
// a time. Digit generation runs first: bases 2, 4, 8 and 16 use shift and
// mask; other bases use the shared restoring divider, which works through the
// value in chunks and retires 8 quotient bits a cycle. Then the DIVIDE state
// sees the quotient run out, SETUP sizes the padding and PLAN picks the first
// phase; then one character is emitted per cycle while the result side keeps
// up. In the cycle after an input item is taken the block starts on it; the
// next item is taken in the cycle after the final character of the current
// one has been moved into the output register.
module integer_to_text_formatter
    import itf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  itf_in_t  s_item,
    input  logic     s_valid,
    output logic     s_ready,
    output itf_out_t m_item,
    output logic     m_valid,
    input  logic     m_ready
);

    itf_cmd_t    cmd;
    itf_status_t status;

    itf_dpath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    itf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

`include "assert_macros.svh"

    // Never overwrite an item still waiting on the output
    `ASSERT_IMPLY(a_emit_slot_free, aclk, aresetn, cmd.emit, status.out_free)
    // Input side closes right after an item is taken
    `ASSERT_NEXT(a_load_closes_input, aclk, aresetn, cmd.load, !s_ready)
    // Nothing is emitted while waiting for an input item
    `ASSERT_IMPLY(a_idle_no_emit, aclk, aresetn, s_ready, !cmd.emit)
    // A bad-base item is a lone NUL marked last
    `ASSERT_IMPLY(a_bad_item_form, aclk, aresetn, m_valid && m_item.bad_base,
                  m_item.last && (m_item.character == CHR_NUL))

endmodule
